FILE: design/twld_pkg.sv
// twld_pkg: shared types, constants and the segment table of the two-wire display writer
// used by twld_digit_split and two_wire_led_display_writer; no dependencies
`default_nettype none

package twld_pkg;

    typedef struct packed {
        logic        start_request;
        logic        opcode;
        logic [7:0]  command_byte;
        logic [15:0] number;
        logic        data_line_in;
    } twld_item_t;

    typedef struct packed {
        logic       clock_level;
        logic       data_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } twld_result_t;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
    } twld_digits_t;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_READY_WAIT_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_WAIT_LIMIT   = 1'b1;

    localparam logic [7:0]  WAIT_LIMIT_RESET = 8'd50;
    localparam logic [7:0]  FRAME_ADDR_CMD   = 8'hC0;
    localparam logic [7:0]  FRAME_TAIL       = 8'h00;
    localparam logic [15:0] BLANK_THRESHOLD  = 16'd1000;

    localparam logic [2:0] LEN_COMMAND = 3'd1;
    localparam logic [2:0] LEN_DIGITS  = 3'd5;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_NO_RELEASE  = 2'd1;
    localparam logic [1:0] STATUS_ACK_MISSING = 2'd2;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

FILE: design/twld_digit_split.sv
// twld_digit_split: splits a number below 1000 into decimal digits, one step per enabled cycle
// reciprocal multiplies with correction; depends on twld_pkg
`default_nettype none

module twld_digit_split (
    input  wire logic                 clk,
    input  wire logic                 step,
    input  wire logic                 load,
    input  wire logic [9:0]           value,
    output      twld_pkg::twld_digits_t digits
);
    import twld_pkg::*;

    logic [9:0]  num_reg;
    logic [3:0]  hund_reg;
    logic [6:0]  rem_reg;
    logic [3:0]  tens_reg;
    logic [3:0]  units_reg;

    logic [15:0] hund_prod;
    logic [9:0]  rem_full;
    logic [13:0] tens_prod;
    logic [6:0]  units_full;

    // x/100 = (x*41)>>12 and x/10 = (x*103)>>10 hold over the ranges used here
    assign hund_prod  = {6'd0, num_reg} * 16'd41;
    assign rem_full   = num_reg - ({6'd0, hund_reg} * 10'd100);
    assign tens_prod  = {7'd0, rem_reg} * 14'd103;
    assign units_full = rem_reg - ({3'd0, tens_reg} * 7'd10);

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (load)
            begin
                num_reg <= value;
            end
            hund_reg  <= hund_prod[15:12];
            rem_reg   <= rem_full[6:0];
            tens_reg  <= tens_prod[13:10];
            units_reg <= units_full[3:0];
        end
    end

    assign digits = {hund_reg, tens_reg, units_reg};

endmodule

`default_nettype wire

FILE: design/two_wire_led_display_writer.sv
// two_wire_led_display_writer: bit-banged two-wire master for a seven-segment LED driver
// depends on twld_pkg and twld_digit_split
//
// Each transaction on the item channel is one bus tick and yields exactly one result
// transaction carrying the line levels and transfer status for that tick. The block takes
// one item per clock sustained unless the result side stalls; an item passes an input
// register and the sequencer step into the result register. Digits of the displayed
// number are worked out by a four-step divider pipeline that runs on the ticks before
// the first digit byte goes out. The user must write the wait limits through the plain
// write port only while no transfer is in progress; the block does not enforce this.
`default_nettype none

module two_wire_led_display_writer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output      logic                             item_stall,
    input  wire twld_pkg::twld_item_t             item,
    output      logic                             result_valid,
    input  wire logic                             result_stall,
    output      twld_pkg::twld_result_t           result,
    input  wire logic                             cfg_write,
    input  wire logic [twld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [twld_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import twld_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_REL_DATA,
        PH_RAISE_CLK,
        PH_READY,
        PH_START_CLK,
        PH_BIT_SET,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_ACK_REL,
        PH_ACK_WAIT,
        PH_ACK_LOW,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C,
        PH_STOP_D
    } phase_t;

    logic [7:0]   ready_limit_reg;
    logic [7:0]   ack_limit_reg;

    logic         hold_valid_reg;
    twld_item_t   hold_item_reg;
    logic         advance;

    twld_result_t result_reg;
    logic         result_valid_reg;

    phase_t       phase_reg, phase_next;
    logic [2:0]   byte_pos_reg, byte_pos_next;
    logic [2:0]   bit_pos_reg, bit_pos_next;
    logic [7:0]   wait_count_reg, wait_count_next;
    logic [2:0]   frame_length_reg, frame_length_next;
    logic         ack_missed_reg, ack_missed_next;
    logic         clock_reg, clock_next;
    logic         data_reg, data_next;
    logic         busy_next;
    logic         done_next;
    logic [1:0]   status_next;

    logic [7:0]   byte0_reg;
    logic         blank_reg;
    logic         start_taken;
    logic         number_blank;
    logic [7:0]   frame_byte;
    logic [7:0]   bit_shifted;
    logic [9:0]   split_value;
    twld_digits_t digits;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_limit_reg <= WAIT_LIMIT_RESET;
            ack_limit_reg   <= WAIT_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_READY_WAIT_LIMIT: ready_limit_reg <= cfg_data;
                CFG_ACK_WAIT_LIMIT:   ack_limit_reg   <= cfg_data;
                default:              ready_limit_reg <= ready_limit_reg;
            endcase
        end
    end

    // input register and handshake
    assign advance    = hold_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = hold_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            hold_item_reg <= item;
        end
    end

    // frame contents
    assign start_taken  = (phase_reg == PH_IDLE) && hold_item_reg.start_request;
    assign number_blank = hold_item_reg.number >= BLANK_THRESHOLD;
    assign split_value  = number_blank ? 10'd0 : hold_item_reg.number[9:0];

    twld_digit_split u_digit_split (
        .clk    (clk),
        .step   (advance),
        .load   (start_taken),
        .value  (split_value),
        .digits (digits)
    );

    always_ff @(posedge clk)
    begin
        if (advance && start_taken)
        begin
            blank_reg <= number_blank;
            if (hold_item_reg.opcode)
            begin
                byte0_reg <= number_blank ? FRAME_TAIL : FRAME_ADDR_CMD;
            end
            else
            begin
                byte0_reg <= hold_item_reg.command_byte;
            end
        end
    end

    always_comb
    begin
        case (byte_pos_reg)
            3'd0:    frame_byte = byte0_reg;
            3'd1:    frame_byte = blank_reg ? FRAME_TAIL : seg_code(digits.hund);
            3'd2:    frame_byte = blank_reg ? FRAME_TAIL : seg_code(digits.tens);
            3'd3:    frame_byte = blank_reg ? FRAME_TAIL : seg_code(digits.units);
            default: frame_byte = FRAME_TAIL;
        endcase
    end

    assign bit_shifted = frame_byte >> bit_pos_reg;

    // sequencer step
    always_comb
    begin
        phase_next        = phase_reg;
        byte_pos_next     = byte_pos_reg;
        bit_pos_next      = bit_pos_reg;
        wait_count_next   = wait_count_reg;
        frame_length_next = frame_length_reg;
        ack_missed_next   = ack_missed_reg;
        clock_next        = clock_reg;
        data_next         = data_reg;
        busy_next         = 1'b1;
        done_next         = 1'b0;
        status_next       = STATUS_OK;

        case (phase_reg)
            PH_IDLE:
            begin
                if (hold_item_reg.start_request)
                begin
                    frame_length_next = hold_item_reg.opcode ? LEN_DIGITS : LEN_COMMAND;
                    byte_pos_next     = 3'd0;
                    bit_pos_next      = 3'd0;
                    wait_count_next   = 8'd0;
                    ack_missed_next   = 1'b0;
                    phase_next        = PH_REL_DATA;
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            PH_REL_DATA:
            begin
                data_next  = 1'b1;
                phase_next = PH_RAISE_CLK;
            end
            PH_RAISE_CLK:
            begin
                clock_next      = 1'b1;
                wait_count_next = 8'd0;
                phase_next      = PH_READY;
            end
            PH_READY:
            begin
                if (wait_count_reg >= ready_limit_reg)
                begin
                    busy_next   = 1'b0;
                    done_next   = 1'b1;
                    status_next = STATUS_NO_RELEASE;
                    phase_next  = PH_IDLE;
                end
                else if (hold_item_reg.data_line_in)
                begin
                    data_next  = 1'b0;
                    phase_next = PH_START_CLK;
                end
                else
                begin
                    wait_count_next = wait_count_reg + 8'd1;
                end
            end
            PH_START_CLK:
            begin
                clock_next    = 1'b0;
                byte_pos_next = 3'd0;
                bit_pos_next  = 3'd0;
                phase_next    = PH_BIT_SET;
            end
            PH_BIT_SET:
            begin
                data_next  = bit_shifted[0];
                phase_next = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                clock_next = 1'b1;
                phase_next = PH_BIT_LOW;
            end
            PH_BIT_LOW:
            begin
                clock_next   = 1'b0;
                bit_pos_next = bit_pos_reg + 3'd1;
                phase_next   = (bit_pos_next == 3'd0) ? PH_ACK_REL : PH_BIT_SET;
            end
            PH_ACK_REL:
            begin
                data_next       = 1'b1;
                wait_count_next = 8'd0;
                phase_next      = PH_ACK_WAIT;
            end
            PH_ACK_WAIT:
            begin
                if ((wait_count_reg >= ack_limit_reg) || !hold_item_reg.data_line_in)
                begin
                    if (wait_count_reg >= ack_limit_reg)
                    begin
                        ack_missed_next = 1'b1;
                    end
                    data_next  = 1'b0;
                    clock_next = 1'b1;
                    phase_next = PH_ACK_LOW;
                end
                else
                begin
                    wait_count_next = wait_count_reg + 8'd1;
                end
            end
            PH_ACK_LOW:
            begin
                clock_next    = 1'b0;
                byte_pos_next = byte_pos_reg + 3'd1;
                phase_next    = (byte_pos_next >= frame_length_reg) ? PH_STOP_A : PH_BIT_SET;
            end
            PH_STOP_A:
            begin
                phase_next = PH_STOP_B;
            end
            PH_STOP_B:
            begin
                data_next  = 1'b0;
                phase_next = PH_STOP_C;
            end
            PH_STOP_C:
            begin
                clock_next = 1'b1;
                phase_next = PH_STOP_D;
            end
            PH_STOP_D:
            begin
                data_next   = 1'b1;
                busy_next   = 1'b0;
                done_next   = 1'b1;
                status_next = ack_missed_reg ? STATUS_ACK_MISSING : STATUS_OK;
                phase_next  = PH_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            byte_pos_reg     <= 3'd0;
            bit_pos_reg      <= 3'd0;
            wait_count_reg   <= 8'd0;
            frame_length_reg <= 3'd0;
            ack_missed_reg   <= 1'b0;
            clock_reg        <= 1'b1;
            data_reg         <= 1'b1;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg              <= phase_next;
                byte_pos_reg           <= byte_pos_next;
                bit_pos_reg            <= bit_pos_next;
                wait_count_reg         <= wait_count_next;
                frame_length_reg       <= frame_length_next;
                ack_missed_reg         <= ack_missed_next;
                clock_reg              <= clock_next;
                data_reg               <= data_next;
                result_valid_reg       <= 1'b1;
                result_reg.clock_level <= clock_next;
                result_reg.data_level  <= data_next;
                result_reg.busy_res    <= busy_next;
                result_reg.done_res    <= done_next;
                result_reg.status      <= status_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> hold_valid_reg && result_valid_reg)
        else $error("input stalled without a waiting result");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed transaction produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |->
            (frame_length_reg == LEN_COMMAND) || (frame_length_reg == LEN_DIGITS))
        else $error("transfer running with bad frame length");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.status != STATUS_OK) |-> result_reg.done_res)
        else $error("status reported without done");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (phase_reg == PH_STOP_D) |=> (phase_reg == PH_IDLE) && data_reg && clock_reg)
        else $error("stop did not leave lines released");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// testbench for two_wire_led_display_writer: drives bus ticks through the item channel and
// checks every result transaction against a cycle-level predictor of the bus sequencer
// depends on twld_pkg and the two_wire_led_display_writer rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import twld_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RELEASE_DATA, ST_RAISE_CLOCK, ST_AWAIT_READY, ST_START_LOW,
        ST_BIT_SET, ST_BIT_HIGH, ST_BIT_LOW, ST_ACK_RELEASE, ST_ACK_WAIT, ST_ACK_LOW,
        ST_STOP_HOLD, ST_STOP_DATA_LOW, ST_STOP_CLOCK_HIGH, ST_STOP_RELEASE
    } seq_state_t;

    typedef enum int {READY_AT_ONCE, READY_LATE, READY_NEVER} ready_mode_t;
    typedef enum int {ACK_AT_ONCE, ACK_LATE, ACK_NEVER} ack_mode_t;

    class wire_level_predictor;
        seq_state_t   ph;
        logic [2:0]   byte_idx;
        logic [2:0]   bit_idx;
        logic [2:0]   frame_len;
        logic [7:0]   waited;
        logic [7:0]   ready_limit;
        logic [7:0]   ack_limit;
        logic [7:0]   frame [5];
        logic [7:0]   glyph [10];
        logic         ack_lost;
        logic         clock_line;
        logic         data_line;
        twld_result_t levels_due [$];
        int           mismatches;

        function new();
            glyph = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
            foreach (frame[i]) frame[i] = 8'h00;
            ready_limit = WAIT_LIMIT_RESET;
            ack_limit = WAIT_LIMIT_RESET;
            ph = ST_IDLE;
            byte_idx = '0;
            bit_idx = '0;
            frame_len = '0;
            waited = '0;
            ack_lost = 1'b0;
            clock_line = 1'b1;
            data_line = 1'b1;
            mismatches = 0;
        endfunction

        function void note_tick(twld_item_t t);
            twld_result_t r;
            int           n;
            logic         busy;
            logic         done;
            logic [1:0]   st;
            busy = 1'b1;
            done = 1'b0;
            st = STATUS_OK;
            case (ph)
                ST_IDLE: begin
                    if (t.start_request) begin
                        if (!t.opcode) begin
                            frame[0] = t.command_byte;
                            frame_len = LEN_COMMAND;
                        end else begin
                            foreach (frame[i]) frame[i] = FRAME_TAIL;
                            if (t.number < BLANK_THRESHOLD) begin
                                n = int'(t.number);
                                frame[0] = FRAME_ADDR_CMD;
                                frame[1] = glyph[n / 100];
                                frame[2] = glyph[(n / 10) % 10];
                                frame[3] = glyph[n % 10];
                            end
                            frame_len = LEN_DIGITS;
                        end
                        byte_idx = '0;
                        bit_idx = '0;
                        waited = '0;
                        ack_lost = 1'b0;
                        ph = ST_RELEASE_DATA;
                    end else begin
                        busy = 1'b0;
                    end
                end
                ST_RELEASE_DATA: begin
                    data_line = 1'b1;
                    ph = ST_RAISE_CLOCK;
                end
                ST_RAISE_CLOCK: begin
                    clock_line = 1'b1;
                    waited = '0;
                    ph = ST_AWAIT_READY;
                end
                ST_AWAIT_READY: begin
                    if (waited >= ready_limit) begin
                        busy = 1'b0;
                        done = 1'b1;
                        st = STATUS_NO_RELEASE;
                        ph = ST_IDLE;
                    end else if (t.data_line_in) begin
                        data_line = 1'b0;
                        ph = ST_START_LOW;
                    end else begin
                        waited++;
                    end
                end
                ST_START_LOW: begin
                    clock_line = 1'b0;
                    byte_idx = '0;
                    bit_idx = '0;
                    ph = ST_BIT_SET;
                end
                ST_BIT_SET: begin
                    data_line = frame[byte_idx][bit_idx];
                    ph = ST_BIT_HIGH;
                end
                ST_BIT_HIGH: begin
                    clock_line = 1'b1;
                    ph = ST_BIT_LOW;
                end
                ST_BIT_LOW: begin
                    clock_line = 1'b0;
                    bit_idx = bit_idx + 3'd1;
                    ph = (bit_idx == 3'd0) ? ST_ACK_RELEASE : ST_BIT_SET;
                end
                ST_ACK_RELEASE: begin
                    data_line = 1'b1;
                    waited = '0;
                    ph = ST_ACK_WAIT;
                end
                ST_ACK_WAIT: begin
                    if (waited >= ack_limit || !t.data_line_in) begin
                        if (waited >= ack_limit) ack_lost = 1'b1;
                        data_line = 1'b0;
                        clock_line = 1'b1;
                        ph = ST_ACK_LOW;
                    end else begin
                        waited++;
                    end
                end
                ST_ACK_LOW: begin
                    clock_line = 1'b0;
                    byte_idx = byte_idx + 3'd1;
                    ph = (byte_idx >= frame_len) ? ST_STOP_HOLD : ST_BIT_SET;
                end
                ST_STOP_HOLD: ph = ST_STOP_DATA_LOW;
                ST_STOP_DATA_LOW: begin
                    data_line = 1'b0;
                    ph = ST_STOP_CLOCK_HIGH;
                end
                ST_STOP_CLOCK_HIGH: begin
                    clock_line = 1'b1;
                    ph = ST_STOP_RELEASE;
                end
                ST_STOP_RELEASE: begin
                    data_line = 1'b1;
                    busy = 1'b0;
                    done = 1'b1;
                    st = ack_lost ? STATUS_ACK_MISSING : STATUS_OK;
                    ph = ST_IDLE;
                end
                default: begin
                    ph = ST_IDLE;
                    busy = 1'b0;
                end
            endcase
            r.clock_level = clock_line;
            r.data_level = data_line;
            r.busy_res = busy;
            r.done_res = done;
            r.status = st;
            levels_due.push_back(r);
        endfunction

        function void check_levels(twld_result_t r);
            twld_result_t e;
            if (levels_due.size() == 0) begin
                $error("result transaction with nothing expected: %h", r);
                mismatches++;
                return;
            end
            e = levels_due.pop_front();
            if (r.clock_level !== e.clock_level) begin
                $error("clock_level: expected %0d, actual %0d", e.clock_level, r.clock_level);
                mismatches++;
            end
            if (r.data_level !== e.data_level) begin
                $error("data_level: expected %0d, actual %0d", e.data_level, r.data_level);
                mismatches++;
            end
            if (r.busy_res !== e.busy_res) begin
                $error("busy_res: expected %0d, actual %0d", e.busy_res, r.busy_res);
                mismatches++;
            end
            if (r.done_res !== e.done_res) begin
                $error("done_res: expected %0d, actual %0d", e.done_res, r.done_res);
                mismatches++;
            end
            if (r.status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, r.status);
                mismatches++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    twld_item_t             item;
    logic                   result_valid;
    logic                   result_stall;
    twld_result_t           result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wire_level_predictor levels;
    int                  burst_left;
    int                  ticks_sent;
    logic                long_hold;

    two_wire_led_display_writer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall) levels.note_tick(item);
            if (result_valid && !result_stall) levels.check_levels(result);
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int seg_len;
        int style;
        result_stall = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (80) @(negedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                seg_len = $urandom_range(1, 40);
                style = $urandom_range(0, 3);
                repeat (seg_len)
                begin
                    case (style)
                        0: result_stall <= 1'b0;
                        1: result_stall <= ($urandom_range(0, 3) == 0);
                        2: result_stall <= ($urandom_range(0, 3) != 0);
                        default: result_stall <= ~result_stall;
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_tick(input twld_item_t t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        item <= t;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        burst_left--;
        ticks_sent++;
        @(negedge clk);
    endtask

    function automatic twld_item_t bus_tick(ready_mode_t rmode, ack_mode_t amode, bit hold);
        twld_item_t t;
        t.start_request = hold ? 1'b1 : 1'($urandom_range(0, 1));
        t.opcode = 1'($urandom_range(0, 1));
        t.command_byte = 8'($urandom);
        t.number = 16'($urandom);
        t.data_line_in = 1'($urandom_range(0, 1));
        if (levels.ph == ST_AWAIT_READY)
        begin
            case (rmode)
                READY_AT_ONCE: t.data_line_in = 1'b1;
                READY_LATE:    t.data_line_in = ($urandom_range(0, 3) != 0);
                default:       t.data_line_in = 1'b0;
            endcase
        end
        else if (levels.ph == ST_ACK_WAIT)
        begin
            case (amode)
                ACK_AT_ONCE: t.data_line_in = 1'b0;
                ACK_LATE:    t.data_line_in = ($urandom_range(0, 2) == 0);
                default:     t.data_line_in = 1'b1;
            endcase
        end
        return t;
    endfunction

    task automatic run_transfer(input logic op, input logic [7:0] cmd, input logic [15:0] num,
                                input ready_mode_t rmode, input ack_mode_t amode,
                                input bit hold);
        twld_item_t t;
        t = bus_tick(rmode, amode, hold);
        t.start_request = 1'b1;
        t.opcode = op;
        t.command_byte = cmd;
        t.number = num;
        send_tick(t);
        while (levels.ph != ST_IDLE)
        begin
            t = bus_tick(rmode, amode, hold);
            send_tick(t);
        end
    endtask

    task automatic apply_limits(input logic [7:0] ready_lim, input logic [7:0] ack_lim);
        item_valid <= 1'b0;
        while (levels.levels_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_READY_WAIT_LIMIT;
        cfg_data <= ready_lim;
        levels.ready_limit = ready_lim;
        @(negedge clk);
        cfg_index <= CFG_ACK_WAIT_LIMIT;
        cfg_data <= ack_lim;
        levels.ack_limit = ack_lim;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_traffic(input int budget);
        int          first;
        logic [15:0] num;
        ready_mode_t rmode;
        ack_mode_t   amode;
        twld_item_t  t;
        first = ticks_sent;
        while (ticks_sent - first < budget)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    t = bus_tick(READY_LATE, ACK_LATE, 1'b0);
                    t.start_request = 1'b0;
                    send_tick(t);
                end
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1, 2: num = 16'($urandom_range(0, 999));
                    3:       num = 16'($urandom_range(1000, 65535));
                    4:       num = 16'($urandom);
                    default:
                        case ($urandom_range(0, 3))
                            0:       num = 16'd0;
                            1:       num = 16'd999;
                            2:       num = 16'd1000;
                            default: num = 16'hFFFF;
                        endcase
                endcase
                case ($urandom_range(0, 9))
                    0:       rmode = READY_NEVER;
                    1, 2:    rmode = READY_AT_ONCE;
                    default: rmode = READY_LATE;
                endcase
                case ($urandom_range(0, 7))
                    0:       amode = ACK_NEVER;
                    1, 2:    amode = ACK_AT_ONCE;
                    default: amode = ACK_LATE;
                endcase
                run_transfer(1'($urandom_range(0, 1)), 8'($urandom), num, rmode, amode,
                             $urandom_range(0, 5) == 0);
            end
        end
    endtask

    initial
    begin
        levels = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_READY_WAIT_LIMIT;
        cfg_data = '0;
        burst_left = 0;
        ticks_sent = 0;
        long_hold = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed transfers at the reset wait limits
        run_transfer(1'b0, 8'hA5, 16'd0, READY_AT_ONCE, ACK_AT_ONCE, 1'b0);
        run_transfer(1'b1, 8'h00, 16'd507, READY_LATE, ACK_LATE, 1'b1);
        run_transfer(1'b0, 8'h5A, 16'd0, READY_NEVER, ACK_AT_ONCE, 1'b0);

        apply_limits(8'd1, 8'd1);
        long_hold = 1'b1;
        run_transfer(1'b0, 8'hC3, 16'd0, READY_AT_ONCE, ACK_NEVER, 1'b0);
        random_traffic(120);

        apply_limits(8'd255, 8'd255);
        run_transfer(1'b0, 8'h3C, 16'd0, READY_LATE, ACK_LATE, 1'b0);

        item_valid <= 1'b0;
        while (levels.levels_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (levels.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
